FILE: hdl/slru_pkg.sv
// Shared constants and control types for the stereo linear resampler.
`timescale 1ns / 1ps
`default_nettype none
package slru_pkg;

	// Field and state widths
	localparam int SAMPLE_BITS = 16;
	localparam int RATE_BITS   = 17;
	localparam int PHASE_BITS  = 18;
	localparam int DIFF_BITS   = SAMPLE_BITS + 1;
	localparam int PROD_BITS   = SAMPLE_BITS + RATE_BITS;

	// Run length limit and counter widths
	localparam int MAX_OUT   = 8;
	localparam int CNT_W     = $clog2(MAX_OUT + 1);
	localparam int DIV_STEPS = SAMPLE_BITS;
	localparam int DCNT_W    = $clog2(DIV_STEPS);

	// Register reset values
	localparam logic [RATE_BITS-1:0] IN_RATE_RESET  = 17'd22047;
	localparam logic [RATE_BITS-1:0] OUT_RATE_RESET = 17'd32000;

	// Register map: one register per 32-bit word, selected by address bit 2
	localparam int   ADDR_W       = 3;
	localparam logic REG_IN_RATE  = 1'b0;
	localparam logic REG_OUT_RATE = 1'b1;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic scan_step;
		logic scan_end;
		logic mul;
		logic div_step;
		logic emit;
		logic commit;
	} slru_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic scan_more;
		logic scan_zero;
		logic div_done;
		logic out_free;
		logic last;
	} slru_sts_t;

endpackage
`default_nettype wire

FILE: hdl/slru_ctrl.sv
// Sequencing state machine for the stereo linear resampler.
`timescale 1ns / 1ps
`default_nettype none
module slru_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  slru_pkg::slru_sts_t sts,
	output slru_pkg::slru_cmd_t cmd
);
	import slru_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_SCAN   = 6'b000010,
		S_MUL    = 6'b000100,
		S_DIV    = 6'b001000,
		S_EMIT   = 6'b010000,
		S_COMMIT = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and command decode.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.scan_more) begin
					cmd.scan_step = 1'b1;
				end else begin
					cmd.scan_end = 1'b1;
					state_d      = sts.scan_zero ? S_COMMIT : S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = sts.last ? S_COMMIT : S_MUL;
				end
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/slru_dp.sv
// Datapath of the stereo linear resampler: phase, multiplier, dividers, output word.
`timescale 1ns / 1ps
`default_nettype none
module slru_dp (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  slru_pkg::slru_cmd_t                    cmd,
	output slru_pkg::slru_sts_t                    sts,
	input  logic signed [slru_pkg::SAMPLE_BITS-1:0] in_left,
	input  logic signed [slru_pkg::SAMPLE_BITS-1:0] in_right,
	input  logic        [slru_pkg::RATE_BITS-1:0]   in_rate,
	input  logic        [slru_pkg::RATE_BITS-1:0]   out_rate,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [slru_pkg::SAMPLE_BITS-1:0] out_left,
	output logic signed [slru_pkg::SAMPLE_BITS-1:0] out_right,
	output logic                                   run_end,
	output logic                                   capped
);
	import slru_pkg::*;

	// Persistent state
	logic [SAMPLE_BITS-1:0] prev_l_q, prev_r_q;
	logic [PHASE_BITS-1:0]  phase_q;

	// Per-word working registers
	logic [SAMPLE_BITS-1:0] new_l_q, new_r_q;
	logic [SAMPLE_BITS-1:0] absd_l_q, absd_r_q;
	logic                   neg_l_q, neg_r_q;
	logic [PHASE_BITS-1:0]  wphase_q;
	logic [PHASE_BITS-1:0]  fin_q;
	logic [CNT_W-1:0]       cnt_q, total_q;
	logic                   cap_q;
	logic [RATE_BITS-1:0]   rem_l_q, rem_r_q;
	logic [SAMPLE_BITS-1:0] quo_l_q, quo_r_q;
	logic [DCNT_W-1:0]      dcnt_q;

	// Output word
	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] out_l_q, out_r_q;
	logic                   run_end_q, capped_q;

	logic [PHASE_BITS-1:0]  out_rate_ext, in_rate_ext;
	logic                   below;
	logic [DIFF_BITS-1:0]   diff_l, diff_r, mag_l, mag_r;
	logic [PROD_BITS-1:0]   prod_l, prod_r;
	logic [RATE_BITS:0]     trial_l, trial_r;
	logic                   ge_l, ge_r;
	logic [RATE_BITS:0]     sub_l, sub_r;
	logic [DIFF_BITS-1:0]   qs_l, qs_r, sum_l, sum_r;

	assign out_rate_ext = {1'b0, out_rate};
	assign in_rate_ext  = {1'b0, in_rate};
	assign below        = wphase_q < out_rate_ext;

	// Status to the controller.
	assign sts.scan_more = below && (cnt_q < CNT_W'(MAX_OUT));
	assign sts.scan_zero = (cnt_q == '0);
	assign sts.div_done  = (dcnt_q == DCNT_W'(DIV_STEPS - 1));
	assign sts.out_free  = !out_valid_q || out_ready;
	assign sts.last      = (CNT_W'(cnt_q + 1'b1) == total_q);

	// Difference to the previous frame, split into sign and magnitude.
	assign diff_l = {in_left[SAMPLE_BITS-1], in_left} - {prev_l_q[SAMPLE_BITS-1], prev_l_q};
	assign diff_r = {in_right[SAMPLE_BITS-1], in_right} - {prev_r_q[SAMPLE_BITS-1], prev_r_q};
	assign mag_l  = diff_l[DIFF_BITS-1] ? (~diff_l + 1'b1) : diff_l;
	assign mag_r  = diff_r[DIFF_BITS-1] ? (~diff_r + 1'b1) : diff_r;

	// Magnitude times phase; the phase is below the 17-bit divisor here.
	assign prod_l = absd_l_q * wphase_q[RATE_BITS-1:0];
	assign prod_r = absd_r_q * wphase_q[RATE_BITS-1:0];

	// One restoring division step per channel.
	assign trial_l = {rem_l_q, quo_l_q[SAMPLE_BITS-1]};
	assign trial_r = {rem_r_q, quo_r_q[SAMPLE_BITS-1]};
	assign ge_l    = trial_l >= {1'b0, out_rate};
	assign ge_r    = trial_r >= {1'b0, out_rate};
	assign sub_l   = trial_l - {1'b0, out_rate};
	assign sub_r   = trial_r - {1'b0, out_rate};

	// Signed quotient added to the previous sample.
	assign qs_l  = neg_l_q ? (~{1'b0, quo_l_q} + 1'b1) : {1'b0, quo_l_q};
	assign qs_r  = neg_r_q ? (~{1'b0, quo_r_q} + 1'b1) : {1'b0, quo_r_q};
	assign sum_l = {prev_l_q[SAMPLE_BITS-1], prev_l_q} + qs_l;
	assign sum_r = {prev_r_q[SAMPLE_BITS-1], prev_r_q} + qs_r;

	// Persistent state: updated once a word's run is finished.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_l_q <= '0;
			prev_r_q <= '0;
			phase_q  <= '0;
		end else if (cmd.commit) begin
			prev_l_q <= new_l_q;
			prev_r_q <= new_r_q;
			phase_q  <= fin_q;
		end
	end

	// Phase walk and output counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			total_q <= '0;
			cap_q   <= 1'b0;
		end else begin
			if (cmd.load || cmd.scan_end) begin
				cnt_q <= '0;
			end else if (cmd.scan_step || cmd.emit) begin
				cnt_q <= CNT_W'(cnt_q + 1'b1);
			end
			if (cmd.scan_end) begin
				total_q <= cnt_q;
				cap_q   <= below;
			end
		end
	end

	// Working phase and the phase left for the next word.
	always_ff @(posedge clk) begin
		if (cmd.load || cmd.scan_end) begin
			wphase_q <= phase_q;
		end else if (cmd.scan_step || cmd.emit) begin
			wphase_q <= wphase_q + in_rate_ext;
		end
		if (cmd.scan_end) begin
			fin_q <= below ? '0 : (wphase_q - out_rate_ext);
		end
	end

	// Captured frame and difference magnitudes.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			new_l_q  <= in_left;
			new_r_q  <= in_right;
			absd_l_q <= mag_l[SAMPLE_BITS-1:0];
			absd_r_q <= mag_r[SAMPLE_BITS-1:0];
			neg_l_q  <= diff_l[DIFF_BITS-1];
			neg_r_q  <= diff_r[DIFF_BITS-1];
		end
	end

	// Dividers: the upper product bits seed the remainder, the lower ones shift in.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (cmd.mul) begin
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			dcnt_q <= DCNT_W'(dcnt_q + 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			rem_l_q <= prod_l[PROD_BITS-1:SAMPLE_BITS];
			rem_r_q <= prod_r[PROD_BITS-1:SAMPLE_BITS];
			quo_l_q <= prod_l[SAMPLE_BITS-1:0];
			quo_r_q <= prod_r[SAMPLE_BITS-1:0];
		end else if (cmd.div_step) begin
			rem_l_q <= ge_l ? sub_l[RATE_BITS-1:0] : trial_l[RATE_BITS-1:0];
			rem_r_q <= ge_r ? sub_r[RATE_BITS-1:0] : trial_r[RATE_BITS-1:0];
			quo_l_q <= {quo_l_q[SAMPLE_BITS-2:0], ge_l};
			quo_r_q <= {quo_r_q[SAMPLE_BITS-2:0], ge_r};
		end
	end

	// Output register: holds a word until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_l_q   <= sum_l[SAMPLE_BITS-1:0];
			out_r_q   <= sum_r[SAMPLE_BITS-1:0];
			run_end_q <= sts.last;
			capped_q  <= cap_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_left  = out_l_q;
	assign out_right = out_r_q;
	assign run_end   = run_end_q;
	assign capped    = capped_q;

endmodule
`default_nettype wire

FILE: hdl/stereo_linear_resampler_unit.sv
// Top level of the stereo linear resampler: register port, controller and datapath.
//
// Usage: each word accepted on in_valid/in_ready is one stereo frame. The unit
// interpolates between the previous frame and the new one at a phase that
// advances by in_rate per output and wraps at out_rate, and returns up to eight
// words on out_valid/out_ready. run_end marks the last word of a frame's run;
// capped marks every word of a run cut at eight words with phase below out_rate.
// Sequence: the unit walks the phase, then per word runs one multiply step, a
// bit-serial divider of sixteen steps and one output step, and at the end
// stores the frame and phase.
// A stalled receiver holds the output register; the unit keeps one word
// computed behind it and waits. After the last word is loaded the unit takes
// the next frame while that word still waits.
// Reset zeroes the previous frame and phase, sets in_rate 22047, out_rate 32000.
// The user must write registers over the APB port only while idle; not enforced.
`timescale 1ns / 1ps
`default_nettype none
module stereo_linear_resampler_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// Register port
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [slru_pkg::ADDR_W-1:0]            paddr,
	input  logic [31:0]                            pwdata,
	output logic [31:0]                            prdata,
	output logic                                   pready,
	// Input frames
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [slru_pkg::SAMPLE_BITS-1:0] in_left,
	input  logic signed [slru_pkg::SAMPLE_BITS-1:0] in_right,
	// Output frames
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [slru_pkg::SAMPLE_BITS-1:0] out_left,
	output logic signed [slru_pkg::SAMPLE_BITS-1:0] out_right,
	output logic                                   run_end,
	output logic                                   capped
);
	import slru_pkg::*;

	logic [RATE_BITS-1:0] in_rate_q, out_rate_q;
	logic                 wr_en;
	slru_cmd_t            cmd;
	slru_sts_t            sts;

	// Register writes complete in the access phase.
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_rate_q  <= IN_RATE_RESET;
			out_rate_q <= OUT_RATE_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_IN_RATE:  in_rate_q  <= pwdata[RATE_BITS-1:0];
				REG_OUT_RATE: out_rate_q <= pwdata[RATE_BITS-1:0];
				default:      in_rate_q  <= in_rate_q;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		unique case (paddr[2])
			REG_IN_RATE:  prdata = 32'(in_rate_q);
			REG_OUT_RATE: prdata = 32'(out_rate_q);
			default:      prdata = '0;
		endcase
	end

	slru_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	slru_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_left   (in_left),
		.in_right  (in_right),
		.in_rate   (in_rate_q),
		.out_rate  (out_rate_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_left  (out_left),
		.out_right (out_right),
		.run_end   (run_end),
		.capped    (capped)
	);

`ifndef SYNTH
	// A new word is never taken in the cycle after one was accepted.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted twice in a row");

	// The output register is only loaded when it is empty or being drained.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid || out_ready))
		else $error("output word overwritten before it was taken");

	// Storing the frame always returns the unit to idle.
	a_commit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> in_ready)
		else $error("unit not idle after storing the frame");
`endif

endmodule
`default_nettype wire
